### hw/rtl/slba_pkg.sv
// Package for the paged bitmap slot allocator.
// Holds the layout constants, request and status codes, and the bitmap search functions.
// No dependencies.
package slba_pkg;

   // Geometry of the page pool.
   localparam int PAGE_COUNT = 64;
   localparam int SLOT_COUNT = 256;
   localparam int PAGE_BYTES = 2048;
   localparam int HDR_BYTES  = 24;
   localparam int PAGE_W     = $clog2(PAGE_COUNT);
   localparam int OPEN_W     = PAGE_W + 1;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int SPP_W      = SLOT_W + 1;
   localparam int OFF_W      = $clog2(PAGE_BYTES);
   localparam int CFG_W      = 11;
   localparam int SIZE_W     = 12;
   localparam int PROD_W     = SLOT_W + SIZE_W;
   localparam int DIV_W      = 16;

   // Largest object that still fits behind the header.
   localparam int MAX_OBJ    = PAGE_BYTES - HDR_BYTES;
   // Bitmap plus data area, in bits, for the slot count formula.
   localparam int AREA_BITS  = (PAGE_BYTES - HDR_BYTES - 8) * 8;

   // Reset layout for 8-byte objects.
   localparam int RST_SIZE   = 8;
   localparam int RST_SPP    = 248;
   localparam int RST_DSTART = 56;

   typedef logic [SLOT_COUNT-1:0] map_word_type;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_PAGE = 2'd1,
      STS_BAD     = 2'd2
   } status_type;

   // Divider command and reply.
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Index of the lowest set bit of a bitmap word.
   function automatic logic [SLOT_W-1:0] lowest_set(input map_word_type vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

   // Index of the highest set bit of a page flag vector.
   function automatic logic [PAGE_W-1:0] highest_set(input logic [PAGE_COUNT-1:0] vec);
      logic [PAGE_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         if (vec[i]) begin
            idx = PAGE_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### hw/rtl/slba_req_if.sv
// Request channel of the paged bitmap slot allocator.
// Depends on slba_pkg for field widths.
interface slba_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [slba_pkg::PAGE_W-1:0]  free_page;
   logic [slba_pkg::OFF_W-1:0]   free_offset;

   modport source (output valid, req_type, free_page, free_offset, input ready);
   modport sink (input valid, req_type, free_page, free_offset, output ready);
endinterface

### hw/rtl/slba_rsp_if.sv
// Response channel of the paged bitmap slot allocator.
// Depends on slba_pkg for field widths.
interface slba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [slba_pkg::PAGE_W-1:0]  obj_page;
   logic [slba_pkg::SLOT_W-1:0]  alloc_slot;
   logic [slba_pkg::OFF_W-1:0]   alloc_offset;

   modport source (output valid, status, obj_page, alloc_slot, alloc_offset, input ready);
   modport sink (input valid, status, obj_page, alloc_slot, alloc_offset, output ready);
endinterface

### hw/rtl/slba_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on slba_pkg for the command and reply structs.
module slba_div (
   input  logic                  clock,
   input  logic                  reset,
   input  slba_pkg::div_req_type div_req,
   output slba_pkg::div_rsp_type div_rsp
);
   import slba_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dsr_ff;
   logic [DIV_W:0]   shifted_in;
   logic             fits_in;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted_in = {rem_ff, quo_ff[DIV_W-1]};
   assign fits_in    = shifted_in >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            done_ff  <= 1'b0;
            count_ff <= CNT_W'(DIV_W);
            rem_ff   <= '0;
            quo_ff   <= div_req.dividend;
            dsr_ff   <= div_req.divisor;
         end else if (busy_ff) begin
            if (fits_in) begin
               rem_ff <= DIV_W'(shifted_in - {1'b0, dsr_ff});
            end else begin
               rem_ff <= shifted_in[DIV_W-1:0];
            end
            quo_ff   <= {quo_ff[DIV_W-2:0], fits_in};
            count_ff <= count_ff - 1'b1;
            done_ff  <= (count_ff == CNT_W'(1));
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### hw/rtl/slba_map_ram.sv
// Slot bitmap memory, one word per page, registered read port.
// Depends on slba_pkg for the geometry.
module slba_map_ram (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [slba_pkg::PAGE_W-1:0] rd_addr,
   output slba_pkg::map_word_type      rd_data,
   input  logic                        wr_en,
   input  logic [slba_pkg::PAGE_W-1:0] wr_addr,
   input  slba_pkg::map_word_type      wr_data
);
   import slba_pkg::*;

   map_word_type mem [PAGE_COUNT];
   map_word_type rd_data_ff;

   // One write and one read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/paged_bitmap_slot_allocator.sv
// Paged bitmap slot allocator: 64 pages of 2048 bytes, one slot bitmap per page.
// Requests are allocate, free (through the 16-step divider) and release all.
// One request at a time; the next one is taken from the cycle after the response is loaded,
// unless an object_size write comes first. Such a write recomputes the layout through the
// divider, or leaves no slots for an oversized object; no request is taken meanwhile.
// Reset closes every page and sets the layout for 8-byte objects; the bitmap memory is not
// cleared, since a page's bitmap is written when it opens.
module paged_bitmap_slot_allocator (
   input  logic                       clock,
   input  logic                       reset,
   slba_req_if.sink                   req_ch,
   slba_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [slba_pkg::CFG_W-1:0] csr_wdata
);
   import slba_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CFG_DIV,
      ST_CFG_FIN,
      ST_ALLOC_WR,
      ST_ALLOC_MUL,
      ST_ALLOC_SUM,
      ST_FREE_DIV,
      ST_FREE_CHK,
      ST_FREE_WR,
      ST_PUSH
   } state_type;

   state_type              state_ff;
   logic [OPEN_W-1:0]      pages_open_ff;
   logic [PAGE_COUNT-1:0]  full_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [SPP_W-1:0]       spp_ff;
   logic [OFF_W-1:0]       dstart_ff;
   map_word_type           mask_ff;
   logic [PAGE_W-1:0]      page_ff;
   logic                   new_page_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [DIV_W-1:0]       quo_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [1:0]             res_status_ff;
   logic [PAGE_W-1:0]      res_page_ff;
   logic [SLOT_W-1:0]      res_slot_ff;
   logic [OFF_W-1:0]       res_off_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [PAGE_W-1:0]      rsp_page_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [OFF_W-1:0]       rsp_off_ff;

   logic [PAGE_COUNT-1:0]  open_in;
   logic [PAGE_COUNT-1:0]  cand_in;
   logic                   accept_in;
   logic [SIZE_W-1:0]      size_in;
   logic                   oversize_in;
   logic                   free_bad_in;
   map_word_type           base_in;
   map_word_type           taken_in;
   logic [SLOT_W-1:0]      pick_in;
   logic [SPP_W-1:0]       spp_in;
   logic                   rsp_free_in;

   logic                   rd_en;
   logic [PAGE_W-1:0]      rd_addr;
   map_word_type           rd_data;
   logic                   wr_en;
   map_word_type           wr_data;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   slba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   slba_map_ram u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (page_ff),
      .wr_data (wr_data)
   );

   // Handshake and request decode.
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_we;
   assign accept_in    = req_ch.valid && req_ch.ready;
   assign rsp_free_in  = !rsp_valid_ff || rsp_ch.ready;

   // Object size rounded up to a multiple of eight.
   assign size_in     = (SIZE_W'(csr_wdata) + SIZE_W'(7)) & ~SIZE_W'(7);
   assign oversize_in = size_in > SIZE_W'(MAX_OBJ);

   // Newest open page that still has a free slot.
   always_comb begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
         open_in[i] = OPEN_W'(i) < pages_open_ff;
      end
   end
   assign cand_in = ~full_ff & open_in;

   // A free is rejected for an unopened page or an offset in front of the data area.
   assign free_bad_in = ({1'b0, req_ch.free_page} >= pages_open_ff) ||
                        (req_ch.free_offset < dstart_ff);

   // Lowest free slot of the page word that was read, or of a fresh page.
   assign base_in  = new_page_ff ? '0 : rd_data;
   assign pick_in  = lowest_set(~base_in & mask_ff);
   assign taken_in = base_in | (map_word_type'(1) << pick_in);

   // Slot count, capped at the bitmap size.
   assign spp_in = (quo_ff > DIV_W'(SLOT_COUNT)) ? SPP_W'(SLOT_COUNT) : SPP_W'(quo_ff);

   // Memory and divider control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = page_ff;
      wr_en   = 1'b0;
      wr_data = taken_in;
      if (state_ff == ST_IDLE && accept_in && req_ch.req_type == REQ_ALLOC && |cand_in) begin
         rd_en   = 1'b1;
         rd_addr = highest_set(cand_in);
      end
      if (state_ff == ST_FREE_CHK && quo_ff < DIV_W'(spp_ff)) begin
         rd_en = 1'b1;
      end
      if (state_ff == ST_ALLOC_WR) begin
         wr_en = 1'b1;
      end
      if (state_ff == ST_FREE_WR) begin
         wr_en   = 1'b1;
         wr_data = rd_data & ~(map_word_type'(1) << quo_ff[SLOT_W-1:0]);
      end
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(req_ch.free_offset - dstart_ff);
      div_req.divisor  = DIV_W'(size_ff);
      if (state_ff == ST_IDLE && csr_we) begin
         div_req.start    = !oversize_in;
         div_req.dividend = DIV_W'(AREA_BITS);
         div_req.divisor  = DIV_W'({size_in, 3'b000}) + DIV_W'(1);
      end else if (accept_in && req_ch.req_type == REQ_FREE) begin
         div_req.start = !free_bad_in && (size_ff != '0);
      end
   end

   // Sequencer, layout registers and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pages_open_ff <= '0;
         size_ff       <= SIZE_W'(RST_SIZE);
         spp_ff        <= SPP_W'(RST_SPP);
         dstart_ff     <= OFF_W'(RST_DSTART);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            mask_ff[i] <= i < RST_SPP;
         end
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The response register empties on its transfer unless a new result loads it.
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_PUSH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               res_page_ff <= '0;
               res_slot_ff <= '0;
               res_off_ff  <= '0;
               if (csr_we) begin
                  size_ff       <= size_in;
                  pages_open_ff <= '0;
                  quo_ff        <= '0;
                  state_ff      <= oversize_in ? ST_CFG_FIN : ST_CFG_DIV;
               end else if (accept_in) begin
                  case (req_kind_type'(req_ch.req_type))
                     REQ_ALLOC: begin
                        if (|cand_in) begin
                           res_status_ff <= STS_OK;
                           new_page_ff   <= 1'b0;
                           page_ff       <= highest_set(cand_in);
                           state_ff      <= ST_ALLOC_WR;
                        end else if (spp_ff == '0 ||
                                     pages_open_ff == OPEN_W'(PAGE_COUNT)) begin
                           res_status_ff <= STS_NO_PAGE;
                           new_page_ff   <= 1'b0;
                           state_ff      <= ST_PUSH;
                        end else begin
                           res_status_ff <= STS_OK;
                           page_ff       <= pages_open_ff[PAGE_W-1:0];
                           new_page_ff   <= 1'b1;
                           pages_open_ff <= pages_open_ff + 1'b1;
                           state_ff      <= ST_ALLOC_WR;
                        end
                     end
                     REQ_FREE: begin
                        page_ff <= req_ch.free_page;
                        quo_ff  <= '0;
                        if (free_bad_in) begin
                           res_status_ff <= STS_BAD;
                           state_ff      <= ST_PUSH;
                        end else if (size_ff == '0) begin
                           res_status_ff <= STS_OK;
                           state_ff      <= ST_FREE_CHK;
                        end else begin
                           res_status_ff <= STS_OK;
                           state_ff      <= ST_FREE_DIV;
                        end
                     end
                     REQ_RELEASE: begin
                        res_status_ff <= STS_OK;
                        pages_open_ff <= '0;
                        state_ff      <= ST_PUSH;
                     end
                     default: begin
                        res_status_ff <= STS_OK;
                        state_ff      <= ST_PUSH;
                     end
                  endcase
               end
            end
            ST_CFG_DIV: begin
               if (div_rsp.done) begin
                  quo_ff   <= div_rsp.quotient;
                  state_ff <= ST_CFG_FIN;
               end
            end
            ST_CFG_FIN: begin
               spp_ff    <= spp_in;
               dstart_ff <= (OFF_W'(32) + OFF_W'(spp_in >> 3)) & ~OFF_W'(7);
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  mask_ff[i] <= SPP_W'(i) < spp_in;
               end
               state_ff <= ST_IDLE;
            end
            ST_ALLOC_WR: begin
               full_ff[page_ff] <= &(taken_in | ~mask_ff);
               slot_ff          <= pick_in;
               state_ff         <= ST_ALLOC_MUL;
            end
            ST_ALLOC_MUL: begin
               prod_ff  <= PROD_W'(slot_ff) * PROD_W'(size_ff);
               state_ff <= ST_ALLOC_SUM;
            end
            ST_ALLOC_SUM: begin
               res_page_ff <= page_ff;
               res_slot_ff <= slot_ff;
               res_off_ff  <= dstart_ff + prod_ff[OFF_W-1:0];
               state_ff    <= ST_PUSH;
            end
            ST_FREE_DIV: begin
               if (div_rsp.done) begin
                  quo_ff   <= div_rsp.quotient;
                  state_ff <= ST_FREE_CHK;
               end
            end
            ST_FREE_CHK: begin
               if (quo_ff < DIV_W'(spp_ff)) begin
                  state_ff <= ST_FREE_WR;
               end else begin
                  res_status_ff <= STS_BAD;
                  state_ff      <= ST_PUSH;
               end
            end
            ST_FREE_WR: begin
               full_ff[page_ff] <= 1'b0;
               state_ff         <= ST_PUSH;
            end
            ST_PUSH: begin
               if (rsp_free_in) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_page_ff   <= res_page_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_off_ff    <= res_off_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Result channel.
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.obj_page     = rsp_page_ff;
   assign rsp_ch.alloc_slot   = rsp_slot_ff;
   assign rsp_ch.alloc_offset = rsp_off_ff;

endmodule
